>>> sv/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

	// Table geometry and code limits
	localparam int SYMBOL_COUNT  = 256;
	localparam int MAX_CODE_BITS = 32;
	localparam int VALUE_BITS    = 32;
	localparam int LEN_CAP       = (MAX_CODE_BITS < VALUE_BITS) ? MAX_CODE_BITS : VALUE_BITS;
	localparam int SYM_W         = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int BYTE_BITS     = 8;
	localparam int WIN_W         = VALUE_BITS + BYTE_BITS;

	// Command codes
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_LOAD   = 2'd0;
	localparam cmd_t CMD_ENCODE = 2'd1;
	localparam cmd_t CMD_FINISH = 2'd2;

	// Result kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_DATA   = 2'd0;
	localparam kind_t KIND_PAD    = 2'd1;
	localparam kind_t KIND_NOCODE = 2'd2;

	// Code table write beat
	typedef struct packed {
		logic                  en;
		logic [SYM_W-1:0]      sym;
		logic [5:0]            size;
		logic [VALUE_BITS-1:0] pattern;
	} tbl_wr_t;

	// Code table read data
	typedef struct packed {
		logic                  present;
		logic [5:0]            size;
		logic [VALUE_BITS-1:0] pattern;
	} tbl_entry_t;

endpackage

>>> sv/huffman_code_bit_packer.sv
// Huffman code bit packer: one item at a time. A load writes the code table RAM.
// An encode gives n output bytes (n from 0 to 4): the table read is registered,
// the code is merged into the 40-bit bit window in the lookup state, then each
// byte goes out of the output register in the emit state; a symbol without a
// code gives one error result after the same read and lookup steps. A finish
// gives r results (1 or 2). An output stall holds the emit state. The code table
// needs no clearing pass: its valid flags reset at once.
module huffman_code_bit_packer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       command,
	input  logic [7:0]                       symbol,
	input  logic [5:0]                       code_length,
	input  logic [31:0]                      code_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	output logic [1:0]                       result_kind,
	output logic                             last_of_run
);
	import hcbp_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_EMIT} state_t;

	state_t               state_q;
	logic                 in_accept;
	logic                 out_free;
	logic                 in_range;
	logic [5:0]           len_sat;
	logic [31:0]          val_mask;
	tbl_wr_t              tbl_wr;
	tbl_entry_t           entry;

	logic [7:0]           pend_byte_q;
	logic [2:0]           pend_cnt_q;
	logic [WIN_W-1:0]     win_q;
	logic [2:0]           bytes_q;
	logic                 tail_q;
	kind_t                tail_kind_q;
	logic [7:0]           tail_byte_q;
	logic [7:0]           sym_s1;
	logic                 range_s1;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	kind_t                out_kind_q;
	logic                 out_last_q;

	logic [5:0]           merge_shift;
	logic [5:0]           merge_total;
	logic [WIN_W-1:0]     merge_win;
	logic [WIN_W-1:0]     merge_rest;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_range  = ({1'b0, symbol} < 9'(SYMBOL_COUNT));

	// Saturate length and mask code bits for a load
	assign len_sat  = (code_length > 6'(LEN_CAP)) ? 6'(LEN_CAP) : code_length;
	assign val_mask = ~(32'hFFFF_FFFF << len_sat);

	assign tbl_wr.en      = in_accept && (command == CMD_LOAD) && in_range;
	assign tbl_wr.sym     = symbol[SYM_W-1:0];
	assign tbl_wr.size    = len_sat;
	assign tbl_wr.pattern = code_value & val_mask;

	hcbp_code_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_en    (in_accept && (command == CMD_ENCODE)),
		.rd_sym   (symbol[SYM_W-1:0]),
		.rd_entry (entry)
	);

	// Merge the code below the pending bits, MSB first
	assign merge_shift = 6'(WIN_W) - {3'b0, pend_cnt_q} - entry.size;
	assign merge_total = {3'b0, pend_cnt_q} + entry.size;
	assign merge_win   = {pend_byte_q, 32'b0} | ({8'b0, entry.pattern} << merge_shift);
	assign merge_rest  = merge_win << {merge_total[5:3], 3'b0};

	// Sequencer, packer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_byte_q <= '0;
			pend_cnt_q  <= '0;
			win_q       <= '0;
			bytes_q     <= '0;
			tail_q      <= 1'b0;
			tail_kind_q <= KIND_DATA;
			tail_byte_q <= '0;
			sym_s1      <= '0;
			range_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_kind_q  <= KIND_DATA;
			out_last_q  <= 1'b0;
		end else begin
			// Load the output register on emit, drop the beat once taken
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (command == CMD_ENCODE)) begin
						sym_s1   <= symbol;
						range_s1 <= in_range;
						state_q  <= ST_LOOKUP;
					end else if (in_accept && (command == CMD_FINISH)) begin
						win_q       <= {pend_byte_q, 32'b0};
						bytes_q     <= (pend_cnt_q != 3'd0) ? 3'd1 : 3'd0;
						tail_q      <= 1'b1;
						tail_kind_q <= KIND_PAD;
						tail_byte_q <= (pend_cnt_q != 3'd0) ? (8'd8 - {5'b0, pend_cnt_q}) : 8'd0;
						pend_byte_q <= '0;
						pend_cnt_q  <= '0;
						state_q     <= ST_EMIT;
					end
				end
				ST_LOOKUP: begin
					if (!range_s1 || !entry.present) begin
						bytes_q     <= '0;
						tail_q      <= 1'b1;
						tail_kind_q <= KIND_NOCODE;
						tail_byte_q <= sym_s1;
						state_q     <= ST_EMIT;
					end else begin
						win_q       <= merge_win;
						bytes_q     <= merge_total[5:3];
						tail_q      <= 1'b0;
						pend_byte_q <= merge_rest[WIN_W-1 -: 8];
						pend_cnt_q  <= merge_total[2:0];
						state_q     <= (merge_total[5:3] == 3'd0) ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (bytes_q != 3'd0) begin
							out_byte_q <= win_q[WIN_W-1 -: 8];
							out_kind_q <= KIND_DATA;
							out_last_q <= (bytes_q == 3'd1) && !tail_q;
							win_q      <= win_q << BYTE_BITS;
							bytes_q    <= bytes_q - 3'd1;
							if ((bytes_q == 3'd1) && !tail_q) begin
								state_q <= ST_IDLE;
							end
						end else begin
							out_byte_q <= tail_byte_q;
							out_kind_q <= tail_kind_q;
							out_last_q <= 1'b1;
							tail_q     <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign result_kind = out_kind_q;
	assign last_of_run = out_last_q;

`ifndef SYNTHESIS
	// A finish leaves the accumulator empty
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (command == CMD_FINISH) |=> (pend_cnt_q == 3'd0) && (pend_byte_q == 8'd0))
		else $error("accumulator not cleared by finish");

	// One code never spans more than four bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		bytes_q <= 3'd4)
		else $error("byte count out of range");

	// Emission always has something left to send
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ((bytes_q != 3'd0) || tail_q))
		else $error("emit state with nothing to send");

	// No input beat while a lookup is under way
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) |-> in_stall)
		else $error("input accepted during lookup");
`endif

endmodule

>>> sv/hcbp_code_table.sv
// Code table: per-symbol valid flags in flops, length and bits in a synchronous RAM.
module hcbp_code_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hcbp_pkg::tbl_wr_t            wr,
	input  logic                         rd_en,
	input  logic [hcbp_pkg::SYM_W-1:0]   rd_sym,
	output hcbp_pkg::tbl_entry_t         rd_entry
);
	import hcbp_pkg::*;

	logic [SYMBOL_COUNT-1:0]      present_q;
	logic [6+VALUE_BITS-1:0]      mem_q [SYMBOL_COUNT];
	logic                         rd_present_q;
	logic [6+VALUE_BITS-1:0]      rd_data_q;

	// Clear valid flags at reset, set on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (wr.en) begin
			present_q[wr.sym] <= 1'b1;
		end
	end

	// Write entry and register read data
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.sym] <= {wr.size, wr.pattern};
		end
		if (rd_en) begin
			rd_data_q    <= mem_q[rd_sym];
			rd_present_q <= present_q[rd_sym];
		end
	end

	assign rd_entry.present = rd_present_q;
	assign rd_entry.size    = rd_data_q[6+VALUE_BITS-1:VALUE_BITS];
	assign rd_entry.pattern = rd_data_q[VALUE_BITS-1:0];

endmodule
